[sv/mcbps_pkg.sv]
// Shared widths, reset values and register indexes for the basket path stepper.
package mcbps_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam int DRAW_W    = 16;
  localparam int PRICE_W   = 32;
  localparam int COEF_W    = 32;
  localparam int STEP_W    = 16;
  localparam int SUM_W     = 48;
  localparam int PATH_W    = 24;
  localparam int FACT_W    = 38;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 82;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL1     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_COM  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_OWN  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT1    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT2    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS    = 8'd7;

  // reset values
  localparam logic [31:0]        RST_GROWTH   = 32'd1073920781;
  localparam logic [30:0]        RST_VOL1     = 31'd6199236;
  localparam logic signed [31:0] RST_MIX_COM  = 32'sd4649427;
  localparam logic [30:0]        RST_MIX_OWN  = 31'd8053064;
  localparam logic [31:0]        RST_SPOT1    = 32'd125829120;
  localparam logic [31:0]        RST_SPOT2    = 32'd104857600;
  localparam logic [31:0]        RST_DISCOUNT = 32'd408549;
  localparam logic [15:0]        RST_STEPS    = 16'd300;

endpackage

[sv/monte_carlo_basket_path_step.sv]
// Top level of the two-asset basket path stepper with one shared multiplier.
// Each accepted transaction carries two normal draws and advances both asset
// prices by one Euler step of geometric Brownian motion. All products go through
// a single registered 33x33 signed multiplier driven by a small sequencer: three
// coefficient products build the two growth factors, then four partial products
// (low 30 and high 6 bits of each factor) scale the two prices. in_stall is
// high while the sequencer steps through states MA to MI after an acceptance.
// On the last step of a path, states PA to PD follow, in which the payoff sum is
// multiplied by the discount in two parts, and PD waits for the result register
// to be free. The result register holds a finished transaction while the next
// draws are accepted, so a stalled output does not hold back the input until
// another path completes. Configuration writes are taken in every cycle
// (cfg_ready is tied high); indexes beyond the register list are dropped.
module monte_carlo_basket_path_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mcbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcbps_pkg::CFG_DAT_W-1:0]      cfg_data,
  // draw input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mcbps_pkg::DRAW_W-1:0]  in_draw_first,
  input  logic signed [mcbps_pkg::DRAW_W-1:0]  in_draw_second,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcbps_pkg::PATH_W-1:0]         out_paths_done,
  output logic [mcbps_pkg::PRICE_W-1:0]        out_premium_estimate
);
  import mcbps_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MA   = 4'd1;   // issue vol1*e1
  localparam logic [3:0] ST_MB   = 4'd2;   // issue mix_common*e1
  localparam logic [3:0] ST_MC   = 4'd3;   // issue mix_own*e2, form factor one
  localparam logic [3:0] ST_MD   = 4'd4;   // issue price1*f1 low
  localparam logic [3:0] ST_ME   = 4'd5;   // issue price1*f1 high, form factor two
  localparam logic [3:0] ST_MF   = 4'd6;   // issue price2*f2 low
  localparam logic [3:0] ST_MG   = 4'd7;   // issue price2*f2 high, update price1
  localparam logic [3:0] ST_MH   = 4'd8;   // fold price2 high product
  localparam logic [3:0] ST_MI   = 4'd9;   // update price2, close path if last step
  localparam logic [3:0] ST_PA   = 4'd10;  // issue sum low * discount
  localparam logic [3:0] ST_PB   = 4'd11;  // issue sum high * discount
  localparam logic [3:0] ST_PC   = 4'd12;  // fold high product
  localparam logic [3:0] ST_PD   = 4'd13;  // load result register

  localparam logic signed [ACC_W-1:0] HALF_Q12 = ACC_W'(2048);
  localparam logic signed [ACC_W-1:0] HALF_Q30 = ACC_W'(64'd536870912);
  localparam logic signed [ACC_W-1:0] HALF_Q32 = ACC_W'(64'd2147483648);

  // configuration registers
  logic [31:0]        growth_r;
  logic [30:0]        vol1_r;
  logic signed [31:0] mix_com_r;
  logic [30:0]        mix_own_r;
  logic [31:0]        spot1_r;
  logic [31:0]        spot2_r;
  logic [31:0]        discount_r;
  logic [15:0]        steps_r;

  // datapath and control registers
  logic [3:0]                state_r, state_nxt;
  logic signed [DRAW_W-1:0]  e1_r, e1_nxt;
  logic signed [DRAW_W-1:0]  e2_r, e2_nxt;
  logic signed [FACT_W-1:0]  f1_r, f1_nxt;
  logic signed [FACT_W-1:0]  f2_r, f2_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [PRICE_W-1:0]        price1_r, price1_nxt;
  logic [PRICE_W-1:0]        price2_r, price2_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [PATH_W-1:0]         paths_r, paths_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PATH_W-1:0]         out_paths_r, out_paths_nxt;
  logic [PRICE_W-1:0]        out_prem_r, out_prem_nxt;

  // shared multiplier operands
  logic signed [MUL_W-1:0]   mul_a, mul_b;

  // helpers
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_round;
  logic signed [ACC_W-1:0]   acc_q12;
  logic signed [FACT_W-1:0]  factor_new;
  logic signed [ACC_W-1:0]   acc_q30;
  logic [PRICE_W-1:0]        price_sat;
  logic                      price_over;
  logic [PRICE_W-1:0]        price2_new;
  logic [PRICE_W-1:0]        best;
  logic [SUM_W:0]            sum_add;
  logic                      last_step;
  logic [PRICE_W-1:0]        prem_sat;
  logic                      res_free;

  assign cfg_ready            = 1'b1;
  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_paths_done       = out_paths_r;
  assign out_premium_estimate = out_prem_r;

  // configuration writes; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      growth_r   <= RST_GROWTH;
      vol1_r     <= RST_VOL1;
      mix_com_r  <= RST_MIX_COM;
      mix_own_r  <= RST_MIX_OWN;
      spot1_r    <= RST_SPOT1;
      spot2_r    <= RST_SPOT2;
      discount_r <= RST_DISCOUNT;
      steps_r    <= RST_STEPS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GROWTH:   growth_r   <= cfg_data;
        REG_VOL1:     vol1_r     <= cfg_data[30:0];
        REG_MIX_COM:  mix_com_r  <= $signed(cfg_data);
        REG_MIX_OWN:  mix_own_r  <= cfg_data[30:0];
        REG_SPOT1:    spot1_r    <= cfg_data;
        REG_SPOT2:    spot2_r    <= cfg_data;
        REG_DISCOUNT: discount_r <= cfg_data;
        REG_STEPS:    steps_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MA: begin
        mul_a = $signed({2'b00, vol1_r});
        mul_b = MUL_W'(e1_r);
      end
      ST_MB: begin
        mul_a = MUL_W'(mix_com_r);
        mul_b = MUL_W'(e1_r);
      end
      ST_MC: begin
        mul_a = $signed({2'b00, mix_own_r});
        mul_b = MUL_W'(e2_r);
      end
      ST_MD: begin
        mul_a = $signed({1'b0, price1_r});
        mul_b = $signed({3'b000, f1_r[29:0]});
      end
      ST_ME: begin
        mul_a = $signed({1'b0, price1_r});
        mul_b = $signed({27'd0, f1_r[35:30]});
      end
      ST_MF: begin
        mul_a = $signed({1'b0, price2_r});
        mul_b = $signed({3'b000, f2_r[29:0]});
      end
      ST_MG: begin
        mul_a = $signed({1'b0, price2_r});
        mul_b = $signed({27'd0, f2_r[35:30]});
      end
      ST_PA: begin
        mul_a = $signed({17'd0, sum_r[15:0]});
        mul_b = $signed({1'b0, discount_r});
      end
      ST_PB: begin
        mul_a = $signed({1'b0, sum_r[47:16]});
        mul_b = $signed({1'b0, discount_r});
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod_r);

  // factor = growth + round-half-up(sum of Q5.42 products to Q2.30)
  assign acc_round  = acc_r + HALF_Q12;
  assign acc_q12    = acc_round >>> 12;
  assign factor_new = FACT_W'(acc_q12) + $signed({6'd0, growth_r});

  // price = round(price * factor >> 30), clamped; acc already holds the half
  assign acc_q30    = acc_r >>> 30;
  assign price_over = |acc_q30[ACC_W-1:PRICE_W];
  assign price_sat  = price_over ? '1 : acc_q30[PRICE_W-1:0];
  assign price2_new = (f2_r > 0) ? price_sat : '0;

  assign best      = (price1_r > price2_new) ? price1_r : price2_new;
  assign sum_add   = {1'b0, sum_r} + {17'd0, best};
  assign last_step = ({1'b0, step_r} + 17'd1) >= {1'b0, steps_r};

  // premium: acc holds sum*disc + half, take bits above 32
  assign prem_sat = (|acc_r[ACC_W-1:64]) ? '1 : acc_r[63:32];
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    f1_nxt        = f1_r;
    f2_nxt        = f2_r;
    acc_nxt       = acc_r;
    price1_nxt    = price1_r;
    price2_nxt    = price2_r;
    step_nxt      = step_r;
    sum_nxt       = sum_r;
    paths_nxt     = paths_r;
    out_paths_nxt = out_paths_r;
    out_prem_nxt  = out_prem_r;
    // drop the result once taken
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          e1_nxt    = in_draw_first;
          e2_nxt    = in_draw_second;
          state_nxt = ST_MA;
        end
      end
      ST_MA: state_nxt = ST_MB;
      ST_MB: begin
        acc_nxt   = prod_ext;
        state_nxt = ST_MC;
      end
      ST_MC: begin
        f1_nxt    = factor_new;
        acc_nxt   = prod_ext;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        acc_nxt   = acc_r + prod_ext;
        state_nxt = ST_ME;
      end
      ST_ME: begin
        f2_nxt    = factor_new;
        acc_nxt   = prod_ext + HALF_Q30;
        state_nxt = ST_MF;
      end
      ST_MF: begin
        acc_nxt   = acc_r + (prod_ext <<< 30);
        state_nxt = ST_MG;
      end
      ST_MG: begin
        price1_nxt = (f1_r > 0) ? price_sat : '0;
        acc_nxt    = prod_ext + HALF_Q30;
        state_nxt  = ST_MH;
      end
      ST_MH: begin
        acc_nxt   = acc_r + (prod_ext <<< 30);
        state_nxt = ST_MI;
      end
      ST_MI: begin
        if (!last_step) begin
          price2_nxt = price2_new;
          step_nxt   = step_r + 16'd1;
          state_nxt  = ST_IDLE;
        end else begin
          // close the path: bank the better asset and reload the spots
          sum_nxt    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          paths_nxt  = (&paths_r) ? paths_r : paths_r + 24'd1;
          price1_nxt = spot1_r;
          price2_nxt = spot2_r;
          step_nxt   = '0;
          state_nxt  = ST_PA;
        end
      end
      ST_PA: state_nxt = ST_PB;
      ST_PB: begin
        acc_nxt   = prod_ext + HALF_Q32;
        state_nxt = ST_PC;
      end
      ST_PC: begin
        acc_nxt   = acc_r + (prod_ext <<< 16);
        state_nxt = ST_PD;
      end
      ST_PD: begin
        // hold until the result register is free
        if (res_free) begin
          out_valid_nxt = 1'b1;
          out_paths_nxt = paths_r;
          out_prem_nxt  = prem_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      price1_r    <= RST_SPOT1;
      price2_r    <= RST_SPOT2;
      step_r      <= '0;
      sum_r       <= '0;
      paths_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      price1_r    <= price1_nxt;
      price2_r    <= price2_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      paths_r     <= paths_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    e1_r        <= e1_nxt;
    e2_r        <= e2_nxt;
    f1_r        <= f1_nxt;
    f2_r        <= f2_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    out_paths_r <= out_paths_nxt;
    out_prem_r  <= out_prem_nxt;
  end

endmodule
